// ===== src/rd_pkg.sv =====
// Shared types and constants for the pinhole ray direction unit.
// Used by the front end, the square-root and divide cells and the top level.
package rd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_DIR   = 3'd0;
  localparam logic [2:0] REG_RIGHT_STEP = 3'd1;
  localparam logic [2:0] REG_DOWN_STEP  = 3'd2;
  localparam logic [2:0] REG_WIDTH      = 3'd3;
  localparam logic [2:0] REG_HEIGHT     = 3'd4;

  localparam int VEC_BITS     = 63;  // three packed components
  localparam int COMP_BITS    = 21;  // signed Q3.17 component
  localparam int RES_BITS     = 13;  // resolution register
  localparam int HalfDivisor  = 2;
  localparam int OFF_BITS     = 14;  // signed offset from image center
  localparam int PROD_BITS    = COMP_BITS + OFF_BITS;
  localparam int D_BITS       = 37;  // signed unnormalized component
  localparam int MAG_BITS     = 36;
  localparam int BL_BITS      = 6;
  localparam int NORM_BITS    = 30;
  localparam int SHAMT_BITS   = 5;
  localparam int SQ_BITS      = 2 * NORM_BITS;
  localparam int SUM_BITS     = 63;
  localparam int SQRT_CELLS   = 32;
  localparam int LEN_BITS     = 32;
  localparam int OUT_BITS     = 16;

  typedef logic [NORM_BITS-1:0] norm_mag_t;

  // Sign and zero-length flags that ride along with each word
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } rd_flags_t;

  // Word handed from one square-root cell to the next
  typedef struct packed {
    logic [SUM_BITS-1:0] rem;
    logic [SUM_BITS-1:0] root;
    norm_mag_t [2:0]     mag;
    rd_flags_t           flags;
  } rd_sqrt_t;

endpackage

// ===== src/rd_front.sv =====
// Front end of the ray direction unit: clamp, center offset, vector sum,
// normalizing shift, squares and their sum. Uses rd_pkg.
module rd_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [COORD_BITS-1:0]             col,
  input  logic [COORD_BITS-1:0]             row,
  input  logic [rd_pkg::VEC_BITS-1:0]       base_direction,
  input  logic [rd_pkg::VEC_BITS-1:0]       right_step,
  input  logic [rd_pkg::VEC_BITS-1:0]       down_step,
  input  logic [rd_pkg::RES_BITS-1:0]       width_pixels,
  input  logic [rd_pkg::RES_BITS-1:0]       height_pixels,
  output logic                              out_valid,
  output rd_pkg::rd_sqrt_t                  out_word
);

  localparam int CW = (COORD_BITS > rd_pkg::RES_BITS) ? COORD_BITS : rd_pkg::RES_BITS;

  logic [6:0] v;

  // stage 1: clamp and offset
  logic [CW-1:0] col_w, row_w, wid_w, hgt_w, colc, rowc;
  logic signed [rd_pkg::OFF_BITS-1:0] offx, offy;
  // stage 2: products
  logic signed [rd_pkg::PROD_BITS-1:0] px [3];
  logic signed [rd_pkg::PROD_BITS-1:0] py [3];
  // stage 3: magnitudes
  logic [rd_pkg::MAG_BITS-1:0] mag3 [3];
  logic [2:0] neg3;
  // stage 4: shift decision
  logic [rd_pkg::MAG_BITS-1:0] mag4 [3];
  logic [2:0] neg4;
  logic degen4, right4;
  logic [rd_pkg::SHAMT_BITS-1:0] amt4;
  // stage 5: normalized magnitudes
  rd_pkg::norm_mag_t [2:0] mag5;
  rd_pkg::rd_flags_t flags5;
  // stage 6: squares
  logic [rd_pkg::SQ_BITS-1:0] sq6 [3];
  rd_pkg::norm_mag_t [2:0] mag6;
  rd_pkg::rd_flags_t flags6;

  logic [rd_pkg::MAG_BITS-1:0] or_mag;
  logic [rd_pkg::BL_BITS-1:0] bl;

  // Advance the valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], in_valid};
    end
  end

  assign col_w = CW'(col);
  assign row_w = CW'(row);
  assign wid_w = CW'(width_pixels);
  assign hgt_w = CW'(height_pixels);
  assign colc  = (col_w > wid_w) ? wid_w : col_w;
  assign rowc  = (row_w > hgt_w) ? hgt_w : row_w;

  // Clamp to the resolution and take the offset from the truncated center
  always_ff @(posedge clk) begin
    if (adv) begin
      offx <= rd_pkg::OFF_BITS'(wid_w / rd_pkg::HalfDivisor) - rd_pkg::OFF_BITS'(colc);
      offy <= rd_pkg::OFF_BITS'(hgt_w / rd_pkg::HalfDivisor) - rd_pkg::OFF_BITS'(rowc);
    end
  end

  // Scale the pixel steps by the offsets
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        px[k] <= $signed(right_step[k*rd_pkg::COMP_BITS +: rd_pkg::COMP_BITS]) * offx;
        py[k] <= $signed(down_step[k*rd_pkg::COMP_BITS +: rd_pkg::COMP_BITS]) * offy;
      end
    end
  end

  // Sum with the base direction, split into sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [rd_pkg::D_BITS-1:0] d;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d = rd_pkg::D_BITS'($signed(base_direction[k*rd_pkg::COMP_BITS +: rd_pkg::COMP_BITS]))
          + rd_pkg::D_BITS'(px[k]) - rd_pkg::D_BITS'(py[k]);
        neg3[k] <= d[rd_pkg::D_BITS-1];
        mag3[k] <= d[rd_pkg::D_BITS-1] ? rd_pkg::MAG_BITS'(-d) : rd_pkg::MAG_BITS'(d);
      end
    end
  end

  // Bit length of the largest magnitude equals that of the OR of all three
  assign or_mag = mag3[0] | mag3[1] | mag3[2];
  always_comb begin
    bl = '0;
    for (int i = 0; i < rd_pkg::MAG_BITS; i++) begin
      if (or_mag[i]) begin
        bl = rd_pkg::BL_BITS'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag4   <= mag3;
      neg4   <= neg3;
      degen4 <= (or_mag == '0);
      right4 <= (bl > rd_pkg::BL_BITS'(rd_pkg::NORM_BITS));
      amt4   <= (bl > rd_pkg::BL_BITS'(rd_pkg::NORM_BITS))
              ? rd_pkg::SHAMT_BITS'(bl - rd_pkg::BL_BITS'(rd_pkg::NORM_BITS))
              : rd_pkg::SHAMT_BITS'(rd_pkg::BL_BITS'(rd_pkg::NORM_BITS) - bl);
    end
  end

  // Shift so the largest magnitude fills the normalized width
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag5[k] <= right4 ? rd_pkg::NORM_BITS'(mag4[k] >> amt4)
                          : rd_pkg::NORM_BITS'(mag4[k] << amt4);
      end
      flags5.neg   <= neg4;
      flags5.degen <= degen4;
    end
  end

  // Square each component
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq6[k] <= mag5[k] * mag5[k];
      end
      mag6   <= mag5;
      flags6 <= flags5;
    end
  end

  // Sum the squares and seed the root chain
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.rem   <= rd_pkg::SUM_BITS'(sq6[0]) + rd_pkg::SUM_BITS'(sq6[1])
                      + rd_pkg::SUM_BITS'(sq6[2]);
      out_word.root  <= '0;
      out_word.mag   <= mag6;
      out_word.flags <= flags6;
    end
  end

  assign out_valid = v[6];

endmodule

// ===== src/rd_sqrt_cell.sv =====
// One step of the digit-by-digit integer square root.
// Uses rd_pkg::rd_sqrt_t; cells are chained in the top level.
module rd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  rd_pkg::rd_sqrt_t  in_word,
  output logic              out_valid,
  output rd_pkg::rd_sqrt_t  out_word
);

  localparam logic [rd_pkg::SUM_BITS-1:0] BITV =
    rd_pkg::SUM_BITS'(1) << (rd_pkg::SUM_BITS - 1 - 2 * STEP);

  logic [rd_pkg::SUM_BITS-1:0] trial;

  assign trial = in_word.root + BITV;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Subtract the trial value where it fits and set this root bit
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.mag   <= in_word.mag;
      out_word.flags <= in_word.flags;
      if (in_word.rem >= trial) begin
        out_word.rem  <= in_word.rem - trial;
        out_word.root <= (in_word.root >> 1) + BITV;
      end else begin
        out_word.rem  <= in_word.rem;
        out_word.root <= in_word.root >> 1;
      end
    end
  end

endmodule

// ===== src/rd_div_cell.sv =====
// One quotient bit of a restoring division for all three components.
// Uses rd_pkg; cells are chained in the top level.
module rd_div_cell #(
  parameter int QW    = 15,
  parameter int RW    = 47,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [2:0][RW-1:0]            in_rem,
  input  logic [2:0][QW-1:0]            in_quo,
  input  logic [rd_pkg::LEN_BITS-1:0]   in_len,
  input  rd_pkg::rd_flags_t             in_flags,
  output logic                          out_valid,
  output logic [2:0][RW-1:0]            out_rem,
  output logic [2:0][QW-1:0]            out_quo,
  output logic [rd_pkg::LEN_BITS-1:0]   out_len,
  output rd_pkg::rd_flags_t             out_flags
);

  logic [RW-1:0] dsor;

  assign dsor = RW'(in_len) << SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Compare against the shifted divisor and shift in one quotient bit
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (in_rem[k] >= dsor) begin
          out_rem[k] <= in_rem[k] - dsor;
          out_quo[k] <= {in_quo[k][QW-2:0], 1'b1};
        end else begin
          out_rem[k] <= in_rem[k];
          out_quo[k] <= {in_quo[k][QW-2:0], 1'b0};
        end
      end
      out_len   <= in_len;
      out_flags <= in_flags;
    end
  end

endmodule

// ===== src/pinhole_ray_direction_unit.sv =====
// Pinhole camera primary ray direction unit: top level.
// Uses rd_pkg, rd_front, rd_sqrt_cell and rd_div_cell.
//
// Input stream s_*: one pixel (column, row) per word. Output stream m_*:
// the unit ray direction in signed fixed point with OUT_FRAC_BITS fraction
// bits, and a degenerate flag in m_tuser when the direction has zero length
// (all components then zero).
// Configuration: cfg_we writes cfg_data into register cfg_addr at the clock
// edge; write only while no word is in flight.
// Throughput: one word per clock while the output is not stalled. The pipeline
// holds 7 front-end stages, 32 square root cells, OUT_FRAC_BITS+1 divide
// cells and the output register. The root chain and the divide chain each
// resolve one result bit per cell.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled receiver freezes every stage and s_tready drops with it.
// Reset clears all valid bits and loads the register reset values
// (vectors zero, resolutions one).
module pinhole_ray_direction_unit #(
  parameter int COORD_BITS    = 12,
  parameter int OUT_FRAC_BITS = 14,
  localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,   // pixel_col, pixel_row
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // dir_x, dir_y, dir_z
  output logic                          m_tuser,   // degenerate
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [rd_pkg::VEC_BITS-1:0]   cfg_data
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int RW = rd_pkg::LEN_BITS + QW;

  logic adv;
  logic [rd_pkg::VEC_BITS-1:0] base_direction, right_step, down_step;
  logic [rd_pkg::RES_BITS-1:0] width_pixels, height_pixels;

  logic             sq_valid [rd_pkg::SQRT_CELLS+1];
  rd_pkg::rd_sqrt_t sq_word  [rd_pkg::SQRT_CELLS+1];

  logic                          dv_valid [QW+1];
  logic [2:0][RW-1:0]            dv_rem   [QW+1];
  logic [2:0][QW-1:0]            dv_quo   [QW+1];
  logic [rd_pkg::LEN_BITS-1:0]   dv_len   [QW+1];
  rd_pkg::rd_flags_t             dv_flags [QW+1];

  logic [rd_pkg::OUT_BITS-1:0] dir [3];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_direction <= '0;
      right_step     <= '0;
      down_step      <= '0;
      width_pixels   <= rd_pkg::RES_BITS'(1);
      height_pixels  <= rd_pkg::RES_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        rd_pkg::REG_BASE_DIR:   base_direction <= cfg_data;
        rd_pkg::REG_RIGHT_STEP: right_step     <= cfg_data;
        rd_pkg::REG_DOWN_STEP:  down_step      <= cfg_data;
        rd_pkg::REG_WIDTH:      width_pixels   <= cfg_data[rd_pkg::RES_BITS-1:0];
        rd_pkg::REG_HEIGHT:     height_pixels  <= cfg_data[rd_pkg::RES_BITS-1:0];
        default: ;
      endcase
    end
  end

  rd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (s_tvalid),
    .col            (s_tdata[COORD_BITS-1:0]),
    .row            (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .base_direction (base_direction),
    .right_step     (right_step),
    .down_step      (down_step),
    .width_pixels   (width_pixels),
    .height_pixels  (height_pixels),
    .out_valid      (sq_valid[0]),
    .out_word       (sq_word[0])
  );

  // Square root chain, one root bit per cell
  for (genvar i = 0; i < rd_pkg::SQRT_CELLS; i++) begin : g_sqrt
    rd_sqrt_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (sq_valid[i]),
      .in_word   (sq_word[i]),
      .out_valid (sq_valid[i+1]),
      .out_word  (sq_word[i+1])
    );
  end

  // Seed the divide chain with the rounded dividends
  assign dv_valid[0] = sq_valid[rd_pkg::SQRT_CELLS];
  assign dv_len[0]   = sq_word[rd_pkg::SQRT_CELLS].root[rd_pkg::LEN_BITS-1:0];
  assign dv_flags[0] = sq_word[rd_pkg::SQRT_CELLS].flags;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] = (RW'(sq_word[rd_pkg::SQRT_CELLS].mag[k]) << OUT_FRAC_BITS)
                   + RW'(dv_len[0] >> 1);
      dv_quo[0][k] = '0;
    end
  end

  // Divide chain, one quotient bit per cell from the top
  for (genvar j = 0; j < QW; j++) begin : g_div
    rd_div_cell #(.QW(QW), .RW(RW), .SHIFT(QW - 1 - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (dv_valid[j]),
      .in_rem    (dv_rem[j]),
      .in_quo    (dv_quo[j]),
      .in_len    (dv_len[j]),
      .in_flags  (dv_flags[j]),
      .out_valid (dv_valid[j+1]),
      .out_rem   (dv_rem[j+1]),
      .out_quo   (dv_quo[j+1]),
      .out_len   (dv_len[j+1]),
      .out_flags (dv_flags[j+1])
    );
  end

  // Apply sign and saturate; a degenerate word gives zero components
  always_comb begin
    logic [31:0] q;
    for (int k = 0; k < 3; k++) begin
      q = 32'(dv_quo[QW][k]);
      if (dv_flags[QW].degen) begin
        dir[k] = '0;
      end else if (dv_flags[QW].neg[k]) begin
        dir[k] = (q > 32'd32768) ? 16'h8000 : 16'(-q);
      end else begin
        dir[k] = (q > 32'd32767) ? 16'h7fff : 16'(q);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {dir[2], dir[1], dir[0]};
      m_tuser <= dv_flags[QW].degen;
    end
  end

endmodule

// ===== src/rd_checker.sv =====
// Port-level checks for the pinhole ray direction unit, bound to the top level.
// Depends only on the top-level ports.
module rd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [47:0]  m_tdata,
  input logic         m_tuser
);

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled output holds back the input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // A zero-length direction carries zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 48'd0)
    else $error("degenerate word with nonzero direction");

  // A unit direction is never all zero
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata != 48'd0)
    else $error("nondegenerate word with zero direction");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && !m_tready) && !$past(rst) |-> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

endmodule

bind pinhole_ray_direction_unit rd_checker u_rd_checker (.*);
